// ===== rtl/assert_macros.svh =====
// Assertion macros used by the point table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");

`endif

// ===== rtl/ptns_pkg.sv =====
// Shared types and constants for the point table search block.
`timescale 1ns / 1ps

package ptns_pkg;

   // Default table capacity.
   localparam int MAX_POINTS_DEF = 64;

   // Fixed field widths.
   localparam int COORD_W     = 16;
   localparam int ID_W        = 16;
   localparam int ENTRY_IDX_W = 6;
   localparam int SQ_W        = 32;
   localparam int DIST_W      = 33;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 1;

   // Operation codes of a request and of a result.
   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_NEAREST    = 2'd1,
      OP_NEIGHBOURS = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NO_MATCH = 2'd2
   } status_type;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] REG_NEAREST_CAP      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_NEIGHBOUR_RADIUS = 1'b1;
   localparam logic [CSR_W-1:0]     NEAREST_CAP_RESET      = 16'd25600;
   localparam logic [CSR_W-1:0]     NEIGHBOUR_RADIUS_RESET = 16'd256;

   // One stored point.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [ID_W-1:0]           id;
   } point_type;

   // One queued request.
   typedef struct packed {
      op_type    op;
      point_type pt;
   } req_type;

   // One result.
   typedef struct packed {
      op_type                 kind;
      status_type             status;
      logic [ENTRY_IDX_W-1:0] index;
      point_type              pt;
      logic [DIST_W-1:0]      d2;
      logic                   last;
   } rsp_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/ptns_front.sv =====
// Request front end: accepts requests, drops unused codes and queues the rest.
`timescale 1ns / 1ps

module ptns_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  ptns_pkg::point_type req_pt,
   output logic               q_valid,
   output ptns_pkg::req_type  q_item,
   input  logic               q_pop
);
   import ptns_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   req_type    q_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       known_op;
   logic       push;

   // Unused operation codes are taken but never queued.
   assign known_op  = (req_op == OP_INSERT) || (req_op == OP_NEAREST) ||
                      (req_op == OP_NEIGHBOURS);
   assign req_ready = (fill_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && known_op;

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = q_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op_type'(req_op), pt: req_pt};
      end
   end

endmodule

// ===== rtl/ptns_back.sv =====
// Back end: point table memory, scan pipeline, search logic and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptns_back #(
   parameter int MAX_POINTS = ptns_pkg::MAX_POINTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  ptns_pkg::req_type            q_item,
   output logic                         q_pop,
   input  logic                         csr_we,
   input  logic [ptns_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptns_pkg::CSR_W-1:0]   csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ptns_pkg::rsp_type            rsp_item
);
   import ptns_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = IDX_W + 1;

   // Configuration and table state.
   logic [CSR_W-1:0] cap_ff, radius_ff;
   logic [CNT_W-1:0] count_ff;
   point_type        mem_ff [MAX_POINTS];

   // Request context.
   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [SQ_W-1:0]         lim_ff;
   logic [IDX_W-1:0]        idx_ff;

   // Scan pipeline stages.
   logic             v1_ff, v2_ff, v3_ff;
   logic             t1_ff, t2_ff, t3_ff;
   logic [IDX_W-1:0] i1_ff, i2_ff, i3_ff;
   point_type        rd_ff, e2_ff, e3_ff;
   logic [COORD_W-1:0] adx_ff, ady_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;

   // Held candidate: running best, or the pending neighbour.
   logic              hv_ff;
   logic [IDX_W-1:0]  hi_ff;
   point_type         he_ff;
   logic [DIST_W-1:0] hd_ff;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Control strobes.
   logic              adv;
   logic              push;
   rsp_type           rsp_new;
   logic              start;
   logic              mem_we;
   logic              ins_ok;
   logic              issue;
   logic              idx_last;
   logic              hold_cap, hold_dist, hold_set;
   logic [CSR_W-1:0]  lim_sel;
   logic [SQ_W-1:0]   lim_sq;
   logic [DIST_W-1:0] d2;
   logic              near_less, nb_match;
   logic              full;
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]  ndx, ndy;

   // The whole pipeline moves only when the result register can take a result.
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign full     = (count_ff == CNT_W'(MAX_POINTS));
   assign idx_last = ({1'b0, idx_ff} == (count_ff - CNT_W'(1)));

   // Squared limit for the operation at the head of the queue.
   assign lim_sel = (q_item.op == OP_NEAREST) ? cap_ff : radius_ff;
   assign lim_sq  = SQ_W'(lim_sel) * SQ_W'(lim_sel);

   // Final stage: sum of squares and the two comparisons.
   assign d2        = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign near_less = (d2 < hd_ff);
   assign nb_match  = (d2 != '0) && (d2 <= {1'b0, lim_ff});

   // Absolute coordinate differences for the second stage.
   assign dx  = $signed({qx_ff[COORD_W-1], qx_ff}) - $signed({rd_ff.x[COORD_W-1], rd_ff.x});
   assign dy  = $signed({qy_ff[COORD_W-1], qy_ff}) - $signed({rd_ff.y[COORD_W-1], rd_ff.y});
   assign ndx = -dx;
   assign ndy = -dy;

   // Sequencer: next state, queue pop and result selection.
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      push      = 1'b0;
      rsp_new   = '0;
      start     = 1'b0;
      mem_we    = 1'b0;
      ins_ok    = 1'b0;
      issue     = 1'b0;
      hold_cap  = 1'b0;
      hold_dist = 1'b0;
      hold_set  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && adv) begin
               q_pop = 1'b1;
               unique case (q_item.op)
                  OP_INSERT: begin
                     push = 1'b1;
                     if (full) begin
                        rsp_new = '{kind: OP_INSERT, status: STAT_FULL, index: '0,
                                    pt: q_item.pt, d2: '0, last: 1'b1};
                     end else begin
                        mem_we  = 1'b1;
                        ins_ok  = 1'b1;
                        rsp_new = '{kind: OP_INSERT, status: STAT_OK,
                                    index: ENTRY_IDX_W'(count_ff[IDX_W-1:0]),
                                    pt: q_item.pt, d2: '0, last: 1'b1};
                     end
                  end
                  OP_NEAREST: begin
                     if (count_ff == '0) begin
                        push    = 1'b1;
                        rsp_new = '{kind: OP_NEAREST, status: STAT_NO_MATCH, index: '0,
                                    pt: '0, d2: DIST_W'(lim_sq), last: 1'b1};
                     end else begin
                        start    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  OP_NEIGHBOURS: begin
                     if (count_ff == '0) begin
                        push    = 1'b1;
                        rsp_new = '{kind: OP_NEIGHBOURS, status: STAT_NO_MATCH, index: '0,
                                    pt: '0, d2: '0, last: 1'b1};
                     end else begin
                        start    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     push = 1'b0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (adv) begin
               issue = 1'b1;
               if (idx_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (adv && v3_ff && t3_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (adv) begin
               push     = 1'b1;
               state_in = S_IDLE;
               if (op_ff == OP_NEAREST) begin
                  rsp_new = '{kind: OP_NEAREST, status: STAT_OK,
                              index: ENTRY_IDX_W'(hi_ff), pt: he_ff, d2: hd_ff,
                              last: 1'b1};
               end else if (hv_ff) begin
                  rsp_new = '{kind: OP_NEIGHBOURS, status: STAT_OK,
                              index: ENTRY_IDX_W'(hi_ff), pt: he_ff, d2: hd_ff,
                              last: 1'b1};
               end else begin
                  rsp_new = '{kind: OP_NEIGHBOURS, status: STAT_NO_MATCH, index: '0,
                              pt: '0, d2: '0, last: 1'b1};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Each entry leaving the pipeline updates the held candidate.
      if (adv && v3_ff) begin
         if (op_ff == OP_NEAREST) begin
            hold_cap  = (i3_ff == '0) || near_less;
            hold_dist = near_less;
         end else begin
            hold_cap  = nb_match;
            hold_dist = nb_match;
            hold_set  = nb_match;
            // A new neighbour releases the previous one as a non-final result.
            if (nb_match && hv_ff) begin
               push    = 1'b1;
               rsp_new = '{kind: OP_NEIGHBOURS, status: STAT_OK,
                           index: ENTRY_IDX_W'(hi_ff), pt: he_ff, d2: hd_ff,
                           last: 1'b0};
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= NEAREST_CAP_RESET;
         radius_ff    <= NEIGHBOUR_RADIUS_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         hv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ins_ok) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_NEAREST_CAP:      cap_ff    <= csr_wdata;
               REG_NEIGHBOUR_RADIUS: radius_ff <= csr_wdata;
               default:              cap_ff    <= cap_ff;
            endcase
         end
         if (adv) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         if (start) begin
            hv_ff <= 1'b0;
         end else if (hold_set) begin
            hv_ff <= 1'b1;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Table memory: one write port for inserts, one registered read port for scans.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[count_ff[IDX_W-1:0]] <= q_item.pt;
      end
      if (adv) begin
         rd_ff <= mem_ff[idx_ff];
      end
   end

   // Datapath registers: request context, pipeline payload, candidate and result.
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff  <= q_item.op;
         qx_ff  <= q_item.pt.x;
         qy_ff  <= q_item.pt.y;
         lim_ff <= lim_sq;
         idx_ff <= '0;
         hd_ff  <= DIST_W'(lim_sq);
      end else begin
         if (issue && !idx_last) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (hold_dist) begin
            hd_ff <= d2;
         end
      end
      if (adv) begin
         t1_ff  <= idx_last;
         i1_ff  <= idx_ff;
         t2_ff  <= t1_ff;
         i2_ff  <= i1_ff;
         e2_ff  <= rd_ff;
         adx_ff <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
         ady_ff <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
         t3_ff  <= t2_ff;
         i3_ff  <= i2_ff;
         e3_ff  <= e2_ff;
         sqx_ff <= SQ_W'(adx_ff) * SQ_W'(adx_ff);
         sqy_ff <= SQ_W'(ady_ff) * SQ_W'(ady_ff);
      end
      if (hold_cap) begin
         hi_ff <= i3_ff;
         he_ff <= e3_ff;
      end
      if (push) begin
         rsp_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Checks on the table count and on the pipeline around request boundaries.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_POINTS))
   `ASSERT_IMPLIES(a_idle_empty, clock, reset, state_ff == S_IDLE, !(v1_ff || v2_ff || v3_ff))
   `ASSERT_IMPLIES(a_finish_empty, clock, reset, state_ff == S_FINISH, !(v1_ff || v2_ff || v3_ff))
   `ASSERT_NEXT(a_insert_count, clock, reset, ins_ok && !reset, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ===== rtl/point_table_nearest_and_radius_search.sv =====
// Top level of the point table with nearest and radius search.
`timescale 1ns / 1ps

// Point table with brute-force nearest and neighbour search.
// Requests arrive on the req_ channel (valid/ready): op 0 inserts a point with
// its id, op 1 asks for the nearest stored point, op 2 asks for all points
// within the neighbour radius. Op 3 is accepted and discarded.
// Results leave on the rsp_ channel (valid/ready), one per insert or nearest
// request and one or more per neighbour request, the final one flagged by last.
// Distances are squared and reported in Q16.16.
// The csr_ port writes nearest_cap (index 0) and neighbour_radius (index 1);
// write it only while no request is in flight.
// A two-entry queue decouples request intake from the search engine.
// An insert, or a query on an empty table, is answered from the queue head
// directly into the result register. A query scans the table one entry per
// cycle while results can be taken, through a read, difference, square and
// compare pipeline; the engine takes no new request until the query is done.
// When the receiver stalls, the result register holds and the scan pipeline
// freezes; the queue keeps taking requests until it is full.
// Reset empties the table and queue and restores both registers to defaults.

module point_table_nearest_and_radius_search #(
   parameter int MAX_POINTS = ptns_pkg::MAX_POINTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_op,
   input  logic signed [ptns_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [ptns_pkg::COORD_W-1:0]   req_point_y,
   input  logic [ptns_pkg::ID_W-1:0]             req_point_id,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [1:0]                            rsp_status,
   output logic [ptns_pkg::ENTRY_IDX_W-1:0]      rsp_entry_index,
   output logic [ptns_pkg::ID_W-1:0]             rsp_entry_id,
   output logic signed [ptns_pkg::COORD_W-1:0]   rsp_entry_x,
   output logic signed [ptns_pkg::COORD_W-1:0]   rsp_entry_y,
   output logic [ptns_pkg::DIST_W-1:0]           rsp_sq_distance,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [ptns_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptns_pkg::CSR_W-1:0]            csr_wdata
);
   import ptns_pkg::*;

   point_type req_pt;
   logic      q_valid;
   req_type   q_item;
   logic      q_pop;
   rsp_type   rsp_item;

   assign req_pt = '{x: req_point_x, y: req_point_y, id: req_point_id};

   // Request intake and queue.
   ptns_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_pt    (req_pt),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Table, search engine and result register.
   ptns_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Result fields.
   assign rsp_kind        = rsp_item.kind;
   assign rsp_status      = rsp_item.status;
   assign rsp_entry_index = rsp_item.index;
   assign rsp_entry_id    = rsp_item.pt.id;
   assign rsp_entry_x     = rsp_item.pt.x;
   assign rsp_entry_y     = rsp_item.pt.y;
   assign rsp_sq_distance = rsp_item.d2;
   assign rsp_last        = rsp_item.last;

endmodule

// ===== dv/point_table_nearest_and_radius_search_test.sv =====
// Self-checking testbench for the point table with nearest and radius search.
`timescale 1ns / 1ps

module point_table_nearest_and_radius_search_test;
   import ptns_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int TABLE_DEPTH   = MAX_POINTS_DEF;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 50;
   // Leave room for a full scan, the queue and the result register.
   localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 8);
   localparam int TIMEOUT_NS    = 10_000_000;

   // One row of the directed stimulus, with an optional hand-written answer.
   typedef struct {
      logic [1:0]                op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [ID_W-1:0]           id;
      bit                        typed;
      rsp_type                   want;
   } probe_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_op = 2'd0;
   logic signed [COORD_W-1:0]    req_point_x = '0;
   logic signed [COORD_W-1:0]    req_point_y = '0;
   logic [ID_W-1:0]              req_point_id = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_kind;
   logic [1:0]                   rsp_status;
   logic [ENTRY_IDX_W-1:0]       rsp_entry_index;
   logic [ID_W-1:0]              rsp_entry_id;
   logic signed [COORD_W-1:0]    rsp_entry_x;
   logic signed [COORD_W-1:0]    rsp_entry_y;
   logic [DIST_W-1:0]            rsp_sq_distance;
   logic                         rsp_last;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_W-1:0]             csr_wdata = '0;

   // Shadow copy of the point table and of the two registers.
   logic signed [COORD_W-1:0]    shadow_x [TABLE_DEPTH];
   logic signed [COORD_W-1:0]    shadow_y [TABLE_DEPTH];
   logic [ID_W-1:0]              shadow_id [TABLE_DEPTH];
   int unsigned                  stored_count = 0;
   logic [CSR_W-1:0]             cap_setting = NEAREST_CAP_RESET;
   logic [CSR_W-1:0]             radius_setting = NEIGHBOUR_RADIUS_RESET;

   rsp_type                      pending_results [$];
   probe_row_type                directed_rows [$];

   int                           mismatches = 0;
   int                           requests_sent = 0;
   int                           results_seen = 0;
   int                           neighbour_matches = 0;
   int                           full_replies = 0;
   int                           burst_left = 0;
   int                           stall_left = 0;
   bit                           calm = 1'b0;

   point_table_nearest_and_radius_search #(
      .MAX_POINTS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_point_id(req_point_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index),
      .rsp_entry_id(rsp_entry_id),
      .rsp_entry_x(rsp_entry_x),
      .rsp_entry_y(rsp_entry_y),
      .rsp_sq_distance(rsp_sq_distance),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Squared distance between two Q8.8 points, in Q16.16.
   function automatic longint sq_gap(input logic signed [COORD_W-1:0] ax,
                                     input logic signed [COORD_W-1:0] ay,
                                     input logic signed [COORD_W-1:0] bx,
                                     input logic signed [COORD_W-1:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return dx * dx + dy * dy;
   endfunction

   // A result that stands alone and so carries the last flag.
   function automatic rsp_type single_result(input op_type kind, input status_type status,
                                             input logic [ENTRY_IDX_W-1:0] index,
                                             input logic [ID_W-1:0] id,
                                             input logic signed [COORD_W-1:0] x,
                                             input logic signed [COORD_W-1:0] y,
                                             input logic [DIST_W-1:0] d2);
      rsp_type res;
      res        = '0;
      res.kind   = kind;
      res.status = status;
      res.index  = index;
      res.pt.id  = id;
      res.pt.x   = x;
      res.pt.y   = y;
      res.d2     = d2;
      res.last   = 1'b1;
      return res;
   endfunction

   function automatic probe_row_type plain_row(input logic [1:0] op,
                                               input logic signed [COORD_W-1:0] x,
                                               input logic signed [COORD_W-1:0] y,
                                               input logic [ID_W-1:0] id);
      probe_row_type row;
      row.op    = op;
      row.x     = x;
      row.y     = y;
      row.id    = id;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic probe_row_type typed_row(input logic [1:0] op,
                                               input logic signed [COORD_W-1:0] x,
                                               input logic signed [COORD_W-1:0] y,
                                               input logic [ID_W-1:0] id,
                                               input rsp_type want);
      probe_row_type row;
      row       = plain_row(op, x, y, id);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input probe_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Append one expected result behind those already waiting.
   function automatic void expect_result(input rsp_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   // Work out the results of one accepted request and update the shadow table.
   task automatic predict_request(input logic [1:0] op,
                                  input logic signed [COORD_W-1:0] qx,
                                  input logic signed [COORD_W-1:0] qy,
                                  input logic [ID_W-1:0] qid);
      longint      best;
      longint      d2;
      longint      r2;
      int unsigned pick;
      bit          have_held;
      rsp_type     res;
      rsp_type     held;
      res       = '0;
      held      = '0;
      have_held = 1'b0;
      res.kind  = op_type'(op);
      res.last  = 1'b1;
      case (op)
         OP_INSERT: begin
            res.pt.x  = qx;
            res.pt.y  = qy;
            res.pt.id = qid;
            if (stored_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_x[stored_count]  = qx;
               shadow_y[stored_count]  = qy;
               shadow_id[stored_count] = qid;
               res.status = STAT_OK;
               res.index  = stored_count[ENTRY_IDX_W-1:0];
               stored_count++;
            end
            expect_result(res);
         end
         OP_NEAREST: begin
            // The first entry strictly below the running best wins; ties keep the earlier one.
            best = longint'(cap_setting) * longint'(cap_setting);
            pick = 0;
            for (int unsigned i = 0; i < stored_count; i++) begin
               d2 = sq_gap(qx, qy, shadow_x[i], shadow_y[i]);
               if (d2 < best) begin
                  best = d2;
                  pick = i;
               end
            end
            if (stored_count == 0) begin
               res.status = STAT_NO_MATCH;
            end else begin
               res.status = STAT_OK;
               res.index  = pick[ENTRY_IDX_W-1:0];
               res.pt.x   = shadow_x[pick];
               res.pt.y   = shadow_y[pick];
               res.pt.id  = shadow_id[pick];
            end
            res.d2 = best[DIST_W-1:0];
            expect_result(res);
         end
         OP_NEIGHBOURS: begin
            // Each match is held back one step so that the final one can be flagged.
            r2 = longint'(radius_setting) * longint'(radius_setting);
            for (int unsigned i = 0; i < stored_count; i++) begin
               d2 = sq_gap(qx, qy, shadow_x[i], shadow_y[i]);
               if (d2 > 0 && d2 <= r2) begin
                  if (have_held) begin
                     expect_result(held);
                  end
                  held        = res;
                  held.status = STAT_OK;
                  held.index  = i[ENTRY_IDX_W-1:0];
                  held.pt.x   = shadow_x[i];
                  held.pt.y   = shadow_y[i];
                  held.pt.id  = shadow_id[i];
                  held.d2     = d2[DIST_W-1:0];
                  held.last   = 1'b0;
                  have_held   = 1'b1;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expect_result(held);
            end else begin
               res.status = STAT_NO_MATCH;
               expect_result(res);
            end
         end
         default: begin
            // The unused code is dropped without a result.
         end
      endcase
   endtask

   // Present a request, with a random gap between bursts if not calm; wait until taken.
   task automatic issue_request(input logic [1:0] op,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic [ID_W-1:0] id);
      if (burst_left == 0) begin
         if (!calm) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_point_x  <= x;
      req_point_y  <= y;
      req_point_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      predict_request(op, x, y, id);
   endtask

   // Let every expected result arrive and the engine fall quiet.
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the enable is lowered in the cycle before the task returns.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == REG_NEAREST_CAP) begin
         cap_setting = value;
      end else begin
         radius_setting = value;
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                              input logic [DIST_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: short stalls at random, none while the run is in a calm stretch.
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                     $time, rsp_kind, rsp_status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (want.kind == OP_NEIGHBOURS && want.status == STAT_OK) neighbour_matches++;
            if (want.status == STAT_FULL) full_replies++;
            check_field("kind", want.kind, rsp_kind);
            check_field("status", want.status, rsp_status);
            check_field("entry_index", want.index, rsp_entry_index);
            check_field("entry_id", want.pt.id, rsp_entry_id);
            check_field("entry_x", want.pt.x, rsp_entry_x);
            check_field("entry_y", want.pt.y, rsp_entry_y);
            check_field("sq_distance", want.d2, rsp_sq_distance);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Stimulus: a directed table, then random phases under changing register settings.
   initial begin
      logic [CSR_W-1:0]          cap_value;
      logic [CSR_W-1:0]          radius_value;
      logic [1:0]                op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic [COORD_W-1:0]        corners [4];
      int unsigned               roll;
      int unsigned               shape;
      int unsigned               pick;

      corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

      // Queries on the empty table, a dropped code, then extremes and ties.
      add_row(typed_row(OP_NEAREST, 16'h0000, 16'h0000, 16'h0000,
         single_result(OP_NEAREST, STAT_NO_MATCH, '0, '0, '0, '0, 33'd655360000)));
      add_row(typed_row(OP_NEIGHBOURS, 16'h7FFF, 16'h8000, 16'hFFFF,
         single_result(OP_NEIGHBOURS, STAT_NO_MATCH, '0, '0, '0, '0, '0)));
      add_row(plain_row(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_row(typed_row(OP_INSERT, 16'h7FFF, 16'h7FFF, 16'hFFFF,
         single_result(OP_INSERT, STAT_OK, 6'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, '0)));
      add_row(typed_row(OP_INSERT, 16'h8000, 16'h8000, 16'h0000,
         single_result(OP_INSERT, STAT_OK, 6'd1, 16'h0000, 16'h8000, 16'h8000, '0)));
      add_row(typed_row(OP_INSERT, 16'h0000, 16'h0000, 16'h1234,
         single_result(OP_INSERT, STAT_OK, 6'd2, 16'h1234, 16'h0000, 16'h0000, '0)));
      add_row(typed_row(OP_INSERT, 16'h0100, 16'h0000, 16'h5A5A,
         single_result(OP_INSERT, STAT_OK, 6'd3, 16'h5A5A, 16'h0100, 16'h0000, '0)));
      add_row(typed_row(OP_INSERT, 16'h0000, 16'hFF00, 16'hA5A5,
         single_result(OP_INSERT, STAT_OK, 6'd4, 16'hA5A5, 16'h0000, 16'hFF00, '0)));
      add_row(typed_row(OP_INSERT, 16'h0000, 16'h0000, 16'h0F0F,
         single_result(OP_INSERT, STAT_OK, 6'd5, 16'h0F0F, 16'h0000, 16'h0000, '0)));
      add_row(plain_row(OP_NEAREST, 16'h0000, 16'h0000, 16'hBEEF));
      add_row(plain_row(OP_NEAREST, 16'h0080, 16'h0000, 16'h0000));
      add_row(plain_row(OP_NEIGHBOURS, 16'h0000, 16'h0000, 16'h0000));
      add_row(plain_row(OP_NEAREST, 16'h8000, 16'h7FFF, 16'h0000));
      add_row(plain_row(OP_NEIGHBOURS, 16'h7FFF, 16'h7FFF, 16'h0000));
      add_row(plain_row(OP_NEAREST, 16'h7FFF, 16'h7FFF, 16'h0000));
      add_row(plain_row(OP_NEIGHBOURS, 16'h0100, 16'h0100, 16'h0000));
      add_row(plain_row(2'd3, 16'h0000, 16'h0000, 16'h0000));
      add_row(plain_row(OP_NEAREST, 16'h8000, 16'h8000, 16'h0000));
      add_row(plain_row(OP_NEIGHBOURS, 16'h8000, 16'h8000, 16'h0000));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         issue_request(directed_rows[r].op, directed_rows[r].x, directed_rows[r].y,
                       directed_rows[r].id);
         // A hand-written answer replaces the computed one for the same request.
         if (directed_rows[r].typed) begin
            void'(pending_results.pop_back());
            expect_result(directed_rows[r].want);
         end
      end
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin cap_value = 16'hFFFF; radius_value = 16'h0400; end
            1: begin cap_value = 16'h0000; radius_value = 16'h0000; end
            2: begin cap_value = NEAREST_CAP_RESET; radius_value = 16'h0200; end
            3: begin
               cap_value    = 16'($urandom_range(0, 16'h0800));
               radius_value = 16'hFFFF;
            end
            4: begin
               cap_value    = 16'($urandom);
               radius_value = 16'($urandom_range(0, 16'h0600));
            end
            default: begin cap_value = 16'h0100; radius_value = 16'($urandom); end
         endcase
         write_register(REG_NEAREST_CAP, cap_value);
         write_register(REG_NEIGHBOUR_RADIUS, radius_value);
         calm     = (phase == 2);
         centre_x = 16'($urandom_range(0, 8191) - 4096);
         centre_y = 16'($urandom_range(0, 8191) - 4096);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) op = 2'd3;
            else if (roll < 40) op = OP_INSERT;
            else if (roll < 70) op = OP_NEAREST;
            else op = OP_NEIGHBOURS;

            // Mostly points in a cluster or on top of stored ones, so that searches hit.
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
               x = 16'($urandom);
               y = 16'($urandom);
            end else if (shape == 1) begin
               x = corners[$urandom_range(0, 3)];
               y = corners[$urandom_range(0, 3)];
            end else if (shape < 6 || stored_count == 0) begin
               x = centre_x + 16'($urandom_range(0, 1023) - 512);
               y = centre_y + 16'($urandom_range(0, 1023) - 512);
            end else begin
               pick = $urandom_range(0, stored_count - 1);
               x    = shadow_x[pick];
               y    = shadow_y[pick];
               if ($urandom_range(0, 1) == 1) begin
                  x = x + 16'($urandom_range(0, 511) - 256);
                  y = y + 16'($urandom_range(0, 511) - 256);
               end
            end
            issue_request(op, x, y, 16'($urandom));
         end
         wait_idle();
      end
      calm = 1'b0;

      $display("Run covered %0d requests and %0d results over %0d register settings.",
               requests_sent, results_seen, PHASE_COUNT + 1);
      $display("Neighbour matches: %0d; inserts refused by a full table: %0d.",
               neighbour_matches, full_replies);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptns_pkg.sv
rtl/ptns_front.sv
rtl/ptns_back.sv
rtl/point_table_nearest_and_radius_search.sv
dv/point_table_nearest_and_radius_search_test.sv
